>>> rtl/tfab_pkg.sv
`timescale 1ns / 1ps

package tfab_pkg;

	localparam int TAG_W = 32;
	localparam int BURST_W = 8;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [BURST_W-1:0] BURST_RESET = 8'd3;

	localparam logic [1:0] OP_ENQ_NORMAL = 2'd0;
	localparam logic [1:0] OP_ENQ_PRIO = 2'd1;
	localparam logic [1:0] OP_SERVE = 2'd2;

	localparam logic [1:0] STAT_PRIO = 2'd0;
	localparam logic [1:0] STAT_NORMAL = 2'd1;
	localparam logic [1:0] STAT_WAIT = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	localparam logic [0:0] REG_BURST_LIMIT = 1'b0;

	typedef struct packed {
		logic [1:0] opcode;
		logic [TAG_W-1:0] item_tag;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [TAG_W-1:0] served_tag;
	} out_item_t;

	typedef struct packed {
		logic wr;
		logic [BURST_W-1:0] limit;
	} cfg_t;

endpackage

>>> rtl/tfab_tag_ram.sv
`timescale 1ns / 1ps

module tfab_tag_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/tfab_apb_regs.sv
`timescale 1ns / 1ps

module tfab_apb_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tfab_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [tfab_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [tfab_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,
	output tfab_pkg::cfg_t                     cfg
);

	logic [tfab_pkg::BURST_W-1:0] burst_limit_q;
	logic hit;
	logic wr;

	assign hit = (paddr[2] == tfab_pkg::REG_BURST_LIMIT);
	assign wr = psel && penable && pwrite && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_limit_q <= tfab_pkg::BURST_RESET;
		end else if (wr) begin
			burst_limit_q <= pwdata[tfab_pkg::BURST_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata[tfab_pkg::BURST_W-1:0] = burst_limit_q;
		end
	end

	assign pready = 1'b1;
	assign cfg.wr = wr;
	assign cfg.limit = wr ? pwdata[tfab_pkg::BURST_W-1:0] : burst_limit_q;

endmodule

>>> rtl/two_class_fifo_burst_arbiter_core.sv
`timescale 1ns / 1ps

// The core takes one transaction in every clock cycle and never raises busy. An enqueue
// that fits produces no result; a serve or an enqueue to a full queue produces exactly one
// result, with done high in the cycle after the transaction, because a served tag comes
// out of a tag memory with a registered read. Results cannot be held off, so the receiver must
// take done whenever it appears.

module two_class_fifo_burst_arbiter_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  tfab_pkg::in_item_t                 item,
	output logic                               busy,
	output logic                               done,
	output tfab_pkg::out_item_t                result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tfab_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [tfab_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [tfab_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	tfab_pkg::cfg_t cfg;

	logic [PTR_W-1:0] p_head_q, p_tail_q, n_head_q, n_tail_q;
	logic [CNT_W-1:0] p_cnt_q, n_cnt_q;
	logic [tfab_pkg::BURST_W-1:0] burst_left_q;
	logic done_q;
	logic [1:0] status_q;
	logic [tfab_pkg::TAG_W-1:0] p_rdata, n_rdata;

	logic accept;
	logic enq_p, enq_n, serve;
	logic p_full, n_full, p_ne, n_ne;
	logic take_p, take_n;
	logic push_p, push_n;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	tfab_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy = 1'b0;
	assign accept = start && !busy;
	assign enq_n = accept && (item.opcode == tfab_pkg::OP_ENQ_NORMAL);
	assign enq_p = accept && (item.opcode == tfab_pkg::OP_ENQ_PRIO);
	assign serve = accept && (item.opcode == tfab_pkg::OP_SERVE);

	assign p_full = (p_cnt_q == CNT_FULL);
	assign n_full = (n_cnt_q == CNT_FULL);
	assign p_ne = (p_cnt_q != '0);
	assign n_ne = (n_cnt_q != '0);

	always_comb begin
		take_p = 1'b0;
		take_n = 1'b0;
		if (serve) begin
			if (burst_left_q != '0) begin
				take_p = p_ne;
				take_n = !p_ne && n_ne;
			end else begin
				take_n = n_ne;
				take_p = !n_ne && p_ne;
			end
		end
	end

	assign push_p = enq_p && !p_full;
	assign push_n = enq_n && !n_full;

	tfab_tag_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(tfab_pkg::TAG_W)) u_prio_ram (
		.clk   (clk),
		.we    (push_p),
		.waddr (p_tail_q),
		.wdata (item.item_tag),
		.re    (take_p),
		.raddr (p_head_q),
		.rdata (p_rdata)
	);

	tfab_tag_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(tfab_pkg::TAG_W)) u_norm_ram (
		.clk   (clk),
		.we    (push_n),
		.waddr (n_tail_q),
		.wdata (item.item_tag),
		.re    (take_n),
		.raddr (n_head_q),
		.rdata (n_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_head_q <= '0;
			p_tail_q <= '0;
			p_cnt_q <= '0;
			n_head_q <= '0;
			n_tail_q <= '0;
			n_cnt_q <= '0;
			burst_left_q <= tfab_pkg::BURST_RESET;
			done_q <= 1'b0;
			status_q <= tfab_pkg::STAT_WAIT;
		end else begin
			done_q <= (enq_p && p_full) || (enq_n && n_full) || serve;
			if (push_p) begin
				p_tail_q <= ptr_next(p_tail_q);
				p_cnt_q <= p_cnt_q + CNT_W'(1);
			end
			if (push_n) begin
				n_tail_q <= ptr_next(n_tail_q);
				n_cnt_q <= n_cnt_q + CNT_W'(1);
			end
			if (take_p) begin
				p_head_q <= ptr_next(p_head_q);
				p_cnt_q <= p_cnt_q - CNT_W'(1);
			end
			if (take_n) begin
				n_head_q <= ptr_next(n_head_q);
				n_cnt_q <= n_cnt_q - CNT_W'(1);
			end
			if (cfg.wr || take_n) begin
				burst_left_q <= cfg.limit;
			end else if (take_p && burst_left_q != '0) begin
				burst_left_q <= burst_left_q - tfab_pkg::BURST_W'(1);
			end
			if (take_p) begin
				status_q <= tfab_pkg::STAT_PRIO;
			end else if (take_n) begin
				status_q <= tfab_pkg::STAT_NORMAL;
			end else if (serve) begin
				status_q <= tfab_pkg::STAT_WAIT;
			end else begin
				status_q <= tfab_pkg::STAT_FULL;
			end
		end
	end

	always_comb begin
		result.status = status_q;
		case (status_q)
			tfab_pkg::STAT_PRIO: result.served_tag = p_rdata;
			tfab_pkg::STAT_NORMAL: result.served_tag = n_rdata;
			default: result.served_tag = '0;
		endcase
	end

	assign done = done_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(p_cnt_q <= CNT_FULL) && (n_cnt_q <= CNT_FULL))
		else $error("Queue occupancy exceeds the depth.");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("Result strobe without a transaction one cycle earlier.");

	a_quiet_enqueue: assert property (@(posedge clk) disable iff (!arst_n)
		(push_p || push_n) |=> !done)
		else $error("An accepted enqueue produced a result.");

	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.wr |-> (burst_left_q <= cfg.limit))
		else $error("Burst counter is above the burst limit.");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int TAG_W = tfab_pkg::TAG_W;
	localparam int BURST_W = tfab_pkg::BURST_W;
	localparam int ADDR_W = tfab_pkg::APB_ADDR_W;
	localparam int DATA_W = tfab_pkg::APB_DATA_W;
	localparam logic [1:0] OP_IDLE = 2'd3;
	localparam int Q_NORMAL = 0;
	localparam int Q_PRIO = 1;
	localparam int DEPTH = 16;
	localparam logic [ADDR_W-1:0] ADDR_BURST_LIMIT =
		ADDR_W'(4 * int'(tfab_pkg::REG_BURST_LIMIT));
	localparam logic [ADDR_W-1:0] ADDR_SPARE = ADDR_BURST_LIMIT + ADDR_W'(4);
	localparam int SETTLE_CYCLES = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 250;

	typedef struct {
		tfab_pkg::in_item_t it;
		int reps;
		bit pinned;
		tfab_pkg::out_item_t want;
	} step_t;

	logic clk;
	logic arst_n;
	logic start;
	tfab_pkg::in_item_t item;
	logic busy;
	logic done;
	tfab_pkg::out_item_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// A typed-in expectation travels with its transaction.
	logic pin_valid;
	tfab_pkg::out_item_t pin_want;

	logic [TAG_W-1:0] tags [2][DEPTH];
	int q_head [2];
	int q_tail [2];
	int q_count [2];
	logic [BURST_W-1:0] limit_q;
	logic [BURST_W-1:0] left_q;

	tfab_pkg::out_item_t awaited [$];
	int n_errors;
	int stalled_cycles;

	step_t plan [12] = '{
		'{'{tfab_pkg::OP_SERVE, 32'h0}, 1, 1'b1, '{tfab_pkg::STAT_WAIT, 32'h0}},
		'{'{OP_IDLE, 32'hFFFF_FFFF}, 1, 1'b0, '0},
		'{'{tfab_pkg::OP_ENQ_NORMAL, 32'h0}, 1, 1'b0, '0},
		'{'{tfab_pkg::OP_ENQ_PRIO, 32'hFFFF_FFFF}, 1, 1'b0, '0},
		'{'{tfab_pkg::OP_SERVE, 32'h0}, 1, 1'b1, '{tfab_pkg::STAT_PRIO, 32'hFFFF_FFFF}},
		'{'{tfab_pkg::OP_SERVE, 32'hFFFF_FFFF}, 1, 1'b1, '{tfab_pkg::STAT_NORMAL, 32'h0}},
		'{'{tfab_pkg::OP_ENQ_PRIO, 32'hA5A5_0000}, DEPTH, 1'b0, '0},
		'{'{tfab_pkg::OP_ENQ_PRIO, 32'h1234_5678}, 1, 1'b1, '{tfab_pkg::STAT_FULL, 32'h0}},
		'{'{tfab_pkg::OP_ENQ_NORMAL, 32'h5A5A_0000}, DEPTH, 1'b0, '0},
		'{'{tfab_pkg::OP_ENQ_NORMAL, 32'hFFFF_FFFF}, 1, 1'b1, '{tfab_pkg::STAT_FULL, 32'h0}},
		'{'{OP_IDLE, 32'h0}, 1, 1'b0, '0},
		'{'{tfab_pkg::OP_SERVE, 32'h0}, 2 * DEPTH + 2, 1'b0, '0}
	};

	two_class_fifo_burst_arbiter_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	function automatic bit push_tag(input int q, input logic [TAG_W-1:0] t);
		if (q_count[q] >= DEPTH)
			return 1'b0;
		tags[q][q_tail[q]] = t;
		q_tail[q] = (q_tail[q] + 1) % DEPTH;
		q_count[q]++;
		return 1'b1;
	endfunction

	function automatic bit pop_tag(input int q, output logic [TAG_W-1:0] t);
		t = '0;
		if (q_count[q] == 0)
			return 1'b0;
		t = tags[q][q_head[q]];
		q_head[q] = (q_head[q] + 1) % DEPTH;
		q_count[q]--;
		return 1'b1;
	endfunction

	// Returns 1 when the transaction produces a result.
	function automatic bit arbitrate(input tfab_pkg::in_item_t it,
		output tfab_pkg::out_item_t res);
		logic [TAG_W-1:0] t;
		res = '0;
		case (it.opcode)
			tfab_pkg::OP_ENQ_NORMAL, tfab_pkg::OP_ENQ_PRIO: begin
				if (push_tag((it.opcode == tfab_pkg::OP_ENQ_PRIO) ? Q_PRIO : Q_NORMAL,
					it.item_tag))
					return 1'b0;
				res.status = tfab_pkg::STAT_FULL;
				return 1'b1;
			end
			tfab_pkg::OP_SERVE: begin
				if (left_q != '0) begin
					if (pop_tag(Q_PRIO, t)) begin
						left_q--;
						res.status = tfab_pkg::STAT_PRIO;
					end else if (pop_tag(Q_NORMAL, t)) begin
						left_q = limit_q;
						res.status = tfab_pkg::STAT_NORMAL;
					end else begin
						res.status = tfab_pkg::STAT_WAIT;
					end
				end else begin
					if (pop_tag(Q_NORMAL, t)) begin
						left_q = limit_q;
						res.status = tfab_pkg::STAT_NORMAL;
					end else if (pop_tag(Q_PRIO, t)) begin
						res.status = tfab_pkg::STAT_PRIO;
					end else begin
						res.status = tfab_pkg::STAT_WAIT;
					end
				end
				res.served_tag = t;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk) begin
		tfab_pkg::out_item_t want;
		tfab_pkg::out_item_t got;
		bit yields;
		bit progress;
		if (arst_n) begin
			progress = 1'b0;
			if (start && !busy) begin
				progress = 1'b1;
				yields = arbitrate(item, want);
				if (pin_valid)
					awaited.push_back(pin_want);
				else if (yields)
					awaited.push_back(want);
			end
			if (psel && penable && pready && paddr == ADDR_BURST_LIMIT) begin
				progress = 1'b1;
				if (pwrite) begin
					limit_q = pwdata[BURST_W-1:0];
					left_q = limit_q;
				end else if (prdata !== DATA_W'(limit_q)) begin
					$error("prdata: expected %h, got %h", DATA_W'(limit_q), prdata);
					n_errors++;
				end
			end
			if (done) begin
				progress = 1'b1;
				got = result;
				if (awaited.size() == 0) begin
					$error("result with no transaction pending: status %0d, served_tag %h",
						got.status, got.served_tag);
					n_errors++;
				end else begin
					want = awaited.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						n_errors++;
					end
					if (got.served_tag !== want.served_tag) begin
						$error("served_tag: expected %h, got %h", want.served_tag,
							got.served_tag);
						n_errors++;
					end
				end
			end
			stalled_cycles <= progress ? 0 : stalled_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send(input tfab_pkg::in_item_t it, input bit pinned,
		input tfab_pkg::out_item_t want);
		start <= 1'b1;
		item <= it;
		pin_valid <= pinned;
		pin_want <= want;
		do @(posedge clk); while (busy);
	endtask

	task automatic apb_access(input bit wr, input logic [ADDR_W-1:0] addr,
		input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic quiesce();
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [BURST_W-1:0] limit);
		logic [DATA_W-1:0] noise;
		noise = $urandom;
		apb_access(1'b1, ADDR_BURST_LIMIT, {noise[DATA_W-1:BURST_W], limit});
		apb_access(1'b0, ADDR_BURST_LIMIT, '0);
	endtask

	task automatic run_random(input int n);
		int sent;
		int burst;
		int enq_pct;
		int pick;
		tfab_pkg::in_item_t it;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 24);
			case ($urandom_range(0, 2))
				0: enq_pct = 20;
				1: enq_pct = 50;
				default: enq_pct = 80;
			endcase
			repeat (burst) begin
				pick = $urandom_range(0, 99);
				if (pick < 3)
					it.opcode = OP_IDLE;
				else if (pick < 3 + enq_pct)
					it.opcode = $urandom_range(0, 1) ? tfab_pkg::OP_ENQ_PRIO
						: tfab_pkg::OP_ENQ_NORMAL;
				else
					it.opcode = tfab_pkg::OP_SERVE;
				case ($urandom_range(0, 9))
					0: it.item_tag = '0;
					1: it.item_tag = '1;
					default: it.item_tag = $urandom;
				endcase
				send(it, 1'b0, '0);
				if (it.opcode != OP_IDLE)
					sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		start <= 1'b0;
	endtask

	initial begin
		logic [BURST_W-1:0] limits [5];
		tfab_pkg::in_item_t it;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		pin_valid = 1'b0;
		pin_want = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		n_errors = 0;
		stalled_cycles = 0;
		for (int q = 0; q < 2; q++) begin
			q_head[q] = 0;
			q_tail[q] = 0;
			q_count[q] = 0;
		end
		limit_q = tfab_pkg::BURST_RESET;
		left_q = tfab_pkg::BURST_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			for (int k = 0; k < plan[i].reps; k++) begin
				it = plan[i].it;
				it.item_tag = it.item_tag + TAG_W'(k);
				send(it, plan[i].pinned, plan[i].want);
				if ($urandom_range(0, 3) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end
			end
		end
		start <= 1'b0;
		quiesce();

		// The spare address decodes to nothing, so the limit must read back unchanged.
		apb_access(1'b1, ADDR_SPARE, $urandom);
		apb_access(1'b0, ADDR_BURST_LIMIT, '0);

		limits = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254)), tfab_pkg::BURST_RESET};
		foreach (limits[i]) begin
			quiesce();
			set_limit(limits[i]);
			run_random(ITEMS_PER_PHASE);
		end

		quiesce();
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
